// ===== sv/gtg_pkg.sv =====
// Shared constants, widths and helpers of the go-to-goal controller.
package gtg_pkg;

    localparam int POS_W     = 36;
    localparam int HEAD_W    = 16;
    localparam int DIFF_W    = POS_W + 1;
    localparam int D_W       = 24;
    localparam int RAD_W     = 2 * D_W;
    localparam int ROOT_W    = D_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int STEP_W    = $clog2(ROOT_W + 1);
    localparam int SPEED_W   = 16;
    localparam int LIMIT_W   = 15;
    localparam int GAIN_W    = 16;
    localparam int ERR_RAW_W = HEAD_W + 1;
    localparam int ERR_W     = 15;
    localparam int AERR_W    = 14;
    localparam int STATUS_W  = 3;
    localparam int MUL_W     = 24;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_NO_TARGET = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_POSE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REACHED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DRIVE     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HALVED    = 3'd4;

    // Angles in 1/4096 rad
    localparam logic signed [ERR_RAW_W-1:0] ANG_PI     = 17'sd12868;
    localparam logic signed [ERR_RAW_W-1:0] ANG_TWO_PI = 17'sd25736;
    localparam logic [AERR_W-1:0]           ANG_QUARTER_PI = 14'd3217;

    localparam logic signed [DIFF_W-1:0] D_MAX = 37'sd8388607;
    localparam logic signed [DIFF_W-1:0] D_MIN = -37'sd8388608;

    function automatic logic signed [D_W-1:0] sat_d(input logic signed [DIFF_W-1:0] v);
        logic signed [D_W-1:0] r;
        if (v > D_MAX)
            r = D_MAX[D_W-1:0];
        else if (v < D_MIN)
            r = D_MIN[D_W-1:0];
        else
            r = v[D_W-1:0];
        return r;
    endfunction

    function automatic logic [D_W-1:0] abs_d(input logic signed [D_W-1:0] v);
        logic [D_W-1:0] r;
        r = v[D_W-1] ? D_W'(-v) : D_W'(v);
        return r;
    endfunction

endpackage

// ===== sv/gtg_in_if.sv =====
// Input channel: target and tick transactions.
interface gtg_in_if;
    import gtg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [HEAD_W-1:0] heading;
    logic                     pose_valid;

    modport source (output valid, kind, pos_x, pos_y, heading, pose_valid, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, heading, pose_valid, output ready);
endinterface

// ===== sv/gtg_out_if.sv =====
// Output channel: velocity command transactions.
interface gtg_out_if;
    import gtg_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] linear_speed;
    logic signed [SPEED_W-1:0] angular_speed;
    logic [D_W-1:0]            distance;
    logic signed [ERR_W-1:0]   heading_error;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, linear_speed, angular_speed, distance, heading_error,
                    status, input ready);
    modport sink   (input valid, linear_speed, angular_speed, distance, heading_error,
                    status, output ready);
endinterface

// ===== sv/go_to_goal_p_controller.sv =====
// Top level of the proportional go-to-goal controller.
// A target transaction (kind 0) stores the goal and gives no command. A tick transaction
// (kind 1) gives exactly one command. With no target held or an invalid pose the tick goes
// straight to the emit state; a tick that reaches the goal first passes the two squares and
// the 24-step bit-serial square root, and any other tick also up to three heading-wrap steps
// and both gains, four passes through the one shared 24x24 multiplier in all. The input is
// not ready while a tick is in work. The command waits in an output register until taken;
// a configuration write also acts on a tick that is in work.
module go_to_goal_p_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    gtg_in_if.sink                         item,
    gtg_out_if.source                      command,
    input  logic                           cfg_we,
    input  logic [gtg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gtg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gtg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ_X, S_SQ_Y, S_SUM, S_ROOT, S_CHECK,
        S_WRAP, S_MUL_LIN, S_MUL_ANG, S_FINISH, S_EMIT
    } state_t;

    state_t                     state_reg, state_next;
    logic [LIMIT_W-1:0]         lin_limit_reg, ang_limit_reg;
    logic [GAIN_W-1:0]          lin_gain_reg, ang_gain_reg;
    logic [D_W-1:0]             tol_reg;
    logic signed [POS_W-1:0]    goal_x_reg, goal_y_reg;
    logic signed [HEAD_W-1:0]   goal_head_reg;
    logic                       goal_held_reg;

    logic signed [D_W-1:0]      dx_reg, dx_next, dy_reg, dy_next;
    logic signed [ERR_RAW_W-1:0] err_reg, err_next;
    logic [PROD_W-1:0]          acc_reg, acc_next;
    logic [D_W-1:0]             dist_reg, dist_next;
    logic [LIMIT_W-1:0]         lin_reg, lin_next;

    logic signed [SPEED_W-1:0]  res_lin_reg, res_lin_next;
    logic signed [SPEED_W-1:0]  res_ang_reg, res_ang_next;
    logic [D_W-1:0]             res_dist_reg, res_dist_next;
    logic signed [ERR_W-1:0]    res_err_reg, res_err_next;
    logic [STATUS_W-1:0]        res_status_reg, res_status_next;

    logic                       out_valid_reg, out_valid_next;
    logic signed [SPEED_W-1:0]  out_lin_reg, out_ang_reg;
    logic [D_W-1:0]             out_dist_reg;
    logic signed [ERR_W-1:0]    out_err_reg;
    logic [STATUS_W-1:0]        out_status_reg;
    logic                       out_load;

    logic                       accept;
    logic signed [DIFF_W-1:0]   diff_x, diff_y;
    logic [MUL_W-1:0]           mul_a, mul_b;
    logic [PROD_W-1:0]          prod;
    logic                       sq_start, sq_done;
    logic [RAD_W-1:0]           sq_rad;
    logic [ROOT_W-1:0]          sq_root;
    logic [AERR_W-1:0]          aerr;
    logic [PROD_W-9:0]          scaled;
    logic [LIMIT_W-1:0]         clamped;
    logic [LIMIT_W-1:0]         lin_final;
    logic                       halve;

    gtg_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    gtg_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign diff_x     = $signed({goal_x_reg[POS_W-1], goal_x_reg})
                      - $signed({item.pos_x[POS_W-1], item.pos_x});
    assign diff_y     = $signed({goal_y_reg[POS_W-1], goal_y_reg})
                      - $signed({item.pos_y[POS_W-1], item.pos_y});
    assign sq_rad     = acc_reg + prod;
    assign sq_start   = (state_reg == S_SUM);
    assign aerr       = err_reg[ERR_RAW_W-1] ? AERR_W'(-err_reg) : AERR_W'(err_reg);
    assign scaled     = prod[PROD_W-1:8];
    assign out_load   = (state_reg == S_EMIT) && (!out_valid_reg || command.ready);

    // Shared multiplier operands per step
    always_comb
    begin
        case (state_reg)
            S_SQ_X:
            begin
                mul_a = abs_d(dx_reg);
                mul_b = abs_d(dx_reg);
            end
            S_SQ_Y:
            begin
                mul_a = abs_d(dy_reg);
                mul_b = abs_d(dy_reg);
            end
            S_MUL_LIN:
            begin
                mul_a = dist_reg;
                mul_b = MUL_W'(lin_gain_reg);
            end
            default:
            begin
                mul_a = MUL_W'(aerr);
                mul_b = MUL_W'(ang_gain_reg);
            end
        endcase
    end

    // Gain product scaled by 1/256 and clamped to the active limit
    always_comb
    begin
        if (state_reg == S_MUL_ANG)
            clamped = (scaled > (PROD_W-8)'(lin_limit_reg)) ? lin_limit_reg
                                                              : scaled[LIMIT_W-1:0];
        else
            clamped = (scaled > (PROD_W-8)'(ang_limit_reg)) ? ang_limit_reg
                                                              : scaled[LIMIT_W-1:0];
        halve     = (aerr > ANG_QUARTER_PI);
        lin_final = halve ? (lin_reg >> 1) : lin_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        err_next        = err_reg;
        acc_next        = acc_reg;
        dist_next       = dist_reg;
        lin_next        = lin_reg;
        res_lin_next    = res_lin_reg;
        res_ang_next    = res_ang_reg;
        res_dist_next   = res_dist_reg;
        res_err_next    = res_err_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && item.kind)
                begin
                    dx_next       = sat_d(diff_x);
                    dy_next       = sat_d(diff_y);
                    err_next      = $signed({goal_head_reg[HEAD_W-1], goal_head_reg})
                                  - $signed({item.heading[HEAD_W-1], item.heading});
                    res_lin_next  = '0;
                    res_ang_next  = '0;
                    res_dist_next = '0;
                    res_err_next  = '0;
                    if (!goal_held_reg)
                    begin
                        res_status_next = ST_NO_TARGET;
                        state_next      = S_EMIT;
                    end
                    else if (!item.pose_valid)
                    begin
                        res_status_next = ST_NO_POSE;
                        state_next      = S_EMIT;
                    end
                    else
                        state_next = S_SQ_X;
                end
            end
            S_SQ_X:
                state_next = S_SQ_Y;
            S_SQ_Y:
            begin
                acc_next   = prod;
                state_next = S_SUM;
            end
            S_SUM:
                state_next = S_ROOT;
            S_ROOT:
            begin
                if (sq_done)
                begin
                    dist_next  = sq_root;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                res_dist_next = dist_reg;
                if (dist_reg < tol_reg)
                begin
                    res_status_next = ST_REACHED;
                    state_next      = S_EMIT;
                end
                else
                    state_next = S_WRAP;
            end
            S_WRAP:
            begin
                // One wrap step per cycle until the error lies in [-pi, pi]
                if (err_reg > ANG_PI)
                    err_next = err_reg - ANG_TWO_PI;
                else if (err_reg < -ANG_PI)
                    err_next = err_reg + ANG_TWO_PI;
                else
                    state_next = S_MUL_LIN;
            end
            S_MUL_LIN:
                state_next = S_MUL_ANG;
            S_MUL_ANG:
            begin
                lin_next   = clamped;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                res_lin_next    = $signed(SPEED_W'(lin_final));
                res_ang_next    = err_reg[ERR_RAW_W-1] ? -$signed(SPEED_W'(clamped))
                                                       : $signed(SPEED_W'(clamped));
                res_err_next    = err_reg[ERR_W-1:0];
                res_status_next = halve ? ST_HALVED : ST_DRIVE;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (command.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            goal_held_reg <= 1'b0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            goal_head_reg <= '0;
            lin_limit_reg <= LIMIT_W'(256);
            ang_limit_reg <= LIMIT_W'(256);
            lin_gain_reg  <= GAIN_W'(256);
            ang_gain_reg  <= GAIN_W'(256);
            tol_reg       <= D_W'(128);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept && !item.kind)
            begin
                goal_held_reg <= 1'b1;
                goal_x_reg    <= item.pos_x;
                goal_y_reg    <= item.pos_y;
                goal_head_reg <= item.heading;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LIN_LIMIT: lin_limit_reg <= cfg_data[LIMIT_W-1:0];
                    CFG_ANG_LIMIT: ang_limit_reg <= cfg_data[LIMIT_W-1:0];
                    CFG_LIN_GAIN:  lin_gain_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_ANG_GAIN:  ang_gain_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_TOLERANCE: tol_reg       <= cfg_data[D_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        err_reg        <= err_next;
        acc_reg        <= acc_next;
        dist_reg       <= dist_next;
        lin_reg        <= lin_next;
        res_lin_reg    <= res_lin_next;
        res_ang_reg    <= res_ang_next;
        res_dist_reg   <= res_dist_next;
        res_err_reg    <= res_err_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_lin_reg    <= res_lin_reg;
            out_ang_reg    <= res_ang_reg;
            out_dist_reg   <= res_dist_reg;
            out_err_reg    <= res_err_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign command.valid         = out_valid_reg;
    assign command.linear_speed  = out_lin_reg;
    assign command.angular_speed = out_ang_reg;
    assign command.distance      = out_dist_reg;
    assign command.heading_error = out_err_reg;
    assign command.status        = out_status_reg;

    a_reached_zero: assert property (@(posedge clk) disable iff (!rst_n)
        command.valid && command.status == ST_REACHED |->
            command.linear_speed == '0 && command.angular_speed == '0
            && command.heading_error == '0)
        else $error("goal reached command carries nonzero speed or error");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready && item.kind && goal_held_reg && item.pose_valid
            |=> !item.ready)
        else $error("input ready while a tick is in work");

    a_err_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        command.valid && (command.status == ST_DRIVE || command.status == ST_HALVED) |->
            $signed(command.heading_error) <= $signed(ANG_PI[ERR_W-1:0])
            && $signed(command.heading_error) >= -$signed(ANG_PI[ERR_W-1:0]))
        else $error("heading error outside [-pi, pi]");

    a_no_target_dist: assert property (@(posedge clk) disable iff (!rst_n)
        command.valid && (command.status == ST_NO_TARGET || command.status == ST_NO_POSE)
            |-> command.distance == '0 && command.linear_speed == '0)
        else $error("command without pose carries distance or speed");

endmodule

// ===== sv/gtg_mul.sv =====
// Shared unsigned multiplier with a registered product.
module gtg_mul (
    input  logic                       clk,
    input  logic [gtg_pkg::MUL_W-1:0]  a,
    input  logic [gtg_pkg::MUL_W-1:0]  b,
    output logic [gtg_pkg::PROD_W-1:0] p
);
    import gtg_pkg::*;

    logic [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;
endmodule

// ===== sv/gtg_isqrt.sv =====
// Bit-serial restoring integer square root, one root bit per cycle.
module gtg_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [gtg_pkg::RAD_W-1:0]  radicand,
    output logic                       done,
    output logic [gtg_pkg::ROOT_W-1:0] root
);
    import gtg_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;
    logic [REM_W+1:0]    diff;

    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        diff      = rem_sh - trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(ROOT_W);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = diff[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ===== dv/gtg_command_checker.sv =====
// Command checker: tracks goal and register state, predicts each command and compares.
`timescale 1ns / 1ps

module gtg_command_checker
    import gtg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    gtg_in_if                     item,
    gtg_out_if                    command,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    pending,
    output int                    mismatches,
    output int                    checked
);

    typedef struct packed {
        logic signed [SPEED_W-1:0] lin;
        logic signed [SPEED_W-1:0] ang;
        logic [D_W-1:0]            distance;
        logic signed [ERR_W-1:0]   err;
        logic [STATUS_W-1:0]       status;
    } command_t;

    command_t expected_cmds[$];
    int       n_bad;
    int       n_checked;

    logic [LIMIT_W-1:0] lin_limit;
    logic [LIMIT_W-1:0] ang_limit;
    logic [GAIN_W-1:0]  lin_gain;
    logic [GAIN_W-1:0]  ang_gain;
    logic [D_W-1:0]     tolerance;

    logic signed [POS_W-1:0]  goal_x;
    logic signed [POS_W-1:0]  goal_y;
    logic signed [HEAD_W-1:0] goal_hd;
    logic                     goal_held;

    function automatic longint clamp_d(input longint v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        rem = n;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe >>= 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem -= root + probe;
                root = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic command_t steer_command(input logic signed [POS_W-1:0] px,
                                               input logic signed [POS_W-1:0] py,
                                               input logic signed [HEAD_W-1:0] hd,
                                               input logic pv);
        command_t        c;
        longint          dx;
        longint          dy;
        longint          lin;
        longint          ang;
        longint unsigned reach;
        int              err;
        int              aerr;
        c = '0;
        if (!goal_held)
        begin
            c.status = ST_NO_TARGET;
            return c;
        end
        if (!pv)
        begin
            c.status = ST_NO_POSE;
            return c;
        end
        dx = clamp_d(longint'(goal_x) - longint'(px));
        dy = clamp_d(longint'(goal_y) - longint'(py));
        reach = floor_sqrt(longint'(dx * dx + dy * dy));
        c.distance = reach[D_W-1:0];
        if (reach < longint'(tolerance))
        begin
            c.status = ST_REACHED;
            return c;
        end
        // wrap into [-pi, pi]
        err = int'(goal_hd) - int'(hd);
        while (err > int'(ANG_PI))
            err -= int'(ANG_TWO_PI);
        while (err < -int'(ANG_PI))
            err += int'(ANG_TWO_PI);
        aerr = (err < 0) ? -err : err;
        lin = (longint'(lin_gain) * longint'(reach)) >>> 8;
        if (lin > longint'(lin_limit))
            lin = longint'(lin_limit);
        ang = (longint'(ang_gain) * longint'(aerr)) >>> 8;
        if (ang > longint'(ang_limit))
            ang = longint'(ang_limit);
        if (err < 0)
            ang = -ang;
        c.status = ST_DRIVE;
        if (aerr > int'(ANG_QUARTER_PI))
        begin
            lin = lin >>> 1;
            c.status = ST_HALVED;
        end
        c.lin = lin[SPEED_W-1:0];
        c.ang = ang[SPEED_W-1:0];
        c.err = err[ERR_W-1:0];
        return c;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        command_t got;
        command_t want;
        if (!rst_n)
        begin
            expected_cmds.delete();
            n_bad = 0;
            n_checked = 0;
            lin_limit = 15'd256;
            ang_limit = 15'd256;
            lin_gain = 16'd256;
            ang_gain = 16'd256;
            tolerance = 24'd128;
            goal_x = '0;
            goal_y = '0;
            goal_hd = '0;
            goal_held = 1'b0;
            pending <= 0;
            mismatches <= 0;
            checked <= 0;
        end
        else
        begin
            // retire the oldest expectation before adding a new one
            if (command.valid && command.ready)
            begin
                got = '{command.linear_speed, command.angular_speed, command.distance,
                        command.heading_error, command.status};
                if (expected_cmds.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("%0t: command transaction with nothing expected", $realtime);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    n_checked++;
                    if (got.lin !== want.lin || got.ang !== want.ang ||
                        got.distance !== want.distance || got.err !== want.err ||
                        got.status !== want.status)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                        begin
                            $write("%0t: command mismatch (exp/act) lin %0d/%0d ang %0d/%0d",
                                   $realtime, want.lin, got.lin, want.ang, got.ang);
                            $display(" dist %0d/%0d err %0d/%0d status %0d/%0d",
                                     want.distance, got.distance, want.err, got.err,
                                     want.status, got.status);
                        end
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                if (item.kind)
                    expected_cmds.push_back(steer_command(item.pos_x, item.pos_y,
                                                          item.heading, item.pose_valid));
                else
                begin
                    goal_x = item.pos_x;
                    goal_y = item.pos_y;
                    goal_hd = item.heading;
                    goal_held = 1'b1;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LIN_LIMIT: lin_limit = cfg_data[LIMIT_W-1:0];
                    CFG_ANG_LIMIT: ang_limit = cfg_data[LIMIT_W-1:0];
                    CFG_LIN_GAIN:  lin_gain = cfg_data[GAIN_W-1:0];
                    CFG_ANG_GAIN:  ang_gain = cfg_data[GAIN_W-1:0];
                    CFG_TOLERANCE: tolerance = cfg_data[D_W-1:0];
                    default: ;
                endcase
            end
            pending <= expected_cmds.size();
            mismatches <= n_bad;
            checked <= n_checked;
        end
    end

endmodule

// ===== dv/tb_go_to_goal_p_controller.sv =====
// Testbench top: drives targets, ticks and register settings into the go-to-goal controller.
`timescale 1ns / 1ps

module tb_go_to_goal_p_controller;
    import gtg_pkg::*;

    localparam logic KIND_TARGET = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam logic signed [POS_W-1:0] POS_MAX = 36'sh7_FFFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 36'sh8_0000_0000;
    localparam logic signed [HEAD_W-1:0] HD_MAX = 16'sh7FFF;
    localparam logic signed [HEAD_W-1:0] HD_MIN = 16'sh8000;

    localparam int N_SETTINGS    = 8;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int src_idle = 25;
    int snk_idle = 49;
    int pending;
    int mismatches;
    int checked;
    int cycles = 0;
    int sent = 0;

    logic signed [POS_W-1:0]  aim_x = '0;
    logic signed [POS_W-1:0]  aim_y = '0;
    logic signed [HEAD_W-1:0] aim_hd = '0;

    gtg_in_if  item();
    gtg_out_if command();

    go_to_goal_p_controller i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .command   (command),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gtg_command_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .command    (command),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .mismatches (mismatches),
        .checked    (checked)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        command.ready <= ($urandom_range(99) >= snk_idle);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Hold valid until the transaction is taken; leave it high for a back-to-back item.
    task automatic send(input logic kind, input logic signed [POS_W-1:0] px,
                        input logic signed [POS_W-1:0] py,
                        input logic signed [HEAD_W-1:0] hd, input logic pv);
        while ($urandom_range(99) < src_idle)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid <= 1'b1;
        item.kind <= kind;
        item.pos_x <= px;
        item.pos_y <= py;
        item.heading <= hd;
        item.pose_valid <= pv;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        item.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // a trailing target leaves no expectation behind, so let it finish
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic apply_setting(input int s);
        logic [CFG_DATA_W-1:0] ll;
        logic [CFG_DATA_W-1:0] al;
        logic [CFG_DATA_W-1:0] lg;
        logic [CFG_DATA_W-1:0] ag;
        logic [CFG_DATA_W-1:0] tol;
        case (s)
            0:
            begin
                ll = 0; al = 0; lg = 0; ag = 0; tol = 0;
            end
            1:
            begin
                ll = 32767; al = 32767; lg = 65535; ag = 65535; tol = 24'hFFFFFF;
            end
            2:
            begin
                ll = 32767; al = 32767; lg = 65535; ag = 65535; tol = 0;
            end
            3:
            begin
                ll = 256; al = 256; lg = 256; ag = 256; tol = 128;
            end
            default:
            begin
                ll = $urandom_range(1) ? $urandom_range(32767) : $urandom_range(2048);
                al = $urandom_range(1) ? $urandom_range(32767) : $urandom_range(2048);
                lg = $urandom_range(1) ? $urandom_range(65535) : $urandom_range(1024);
                ag = $urandom_range(1) ? $urandom_range(65535) : $urandom_range(1024);
                tol = ($urandom_range(3) == 0) ? $urandom_range(24'hFFFFFF)
                                               : $urandom_range(4096);
            end
        endcase
        write_reg(CFG_LIN_LIMIT, ll);
        write_reg(CFG_ANG_LIMIT, al);
        write_reg(CFG_LIN_GAIN, lg);
        write_reg(CFG_ANG_GAIN, ag);
        write_reg(CFG_TOLERANCE, tol);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [POS_W-1:0] any_pos();
        return POS_W'({$urandom(), $urandom()});
    endfunction

    // Offset around a base at one of several scales, from inside tolerance to saturation.
    function automatic logic signed [POS_W-1:0] near_pos(input logic signed [POS_W-1:0] base);
        longint span;
        case ($urandom_range(3))
            0: span = 512;
            1: span = 65536;
            2: span = 64'd1 << 23;
            default: span = 64'd1 << 30;
        endcase
        return POS_W'(longint'(base) + longint'($urandom_range(2 * span)) - span);
    endfunction

    task automatic random_item();
        int                       pick;
        logic signed [HEAD_W-1:0] hd;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            if ($urandom_range(1))
            begin
                aim_x = any_pos();
                aim_y = any_pos();
            end
            else
            begin
                aim_x = near_pos('0);
                aim_y = near_pos('0);
            end
            aim_hd = HEAD_W'($urandom());
            send(KIND_TARGET, aim_x, aim_y, aim_hd, 1'($urandom_range(1)));
        end
        else if (pick < 22)
            send(KIND_TICK, any_pos(), any_pos(), HEAD_W'($urandom()), 1'($urandom_range(1)));
        else
        begin
            if ($urandom_range(3) == 0)
                hd = HEAD_W'($urandom());
            else
                hd = HEAD_W'(int'(aim_hd) + int'($urandom_range(8192)) - 4096);
            send(KIND_TICK, near_pos(aim_x), near_pos(aim_y), hd, $urandom_range(9) != 0);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        item.valid <= 1'b0;
        item.kind <= KIND_TARGET;
        item.pos_x <= '0;
        item.pos_y <= '0;
        item.heading <= '0;
        item.pose_valid <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_LIN_LIMIT;
        cfg_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // ticks before any target, then reached, no pose and the tolerance boundary
        send(KIND_TICK, '0, '0, '0, 1'b1);
        send(KIND_TICK, POS_MAX, POS_MIN, HD_MAX, 1'b0);
        send(KIND_TARGET, '0, '0, '0, 1'b0);
        send(KIND_TICK, '0, '0, '0, 1'b1);
        send(KIND_TICK, 36'sd5000, '0, '0, 1'b0);
        send(KIND_TICK, 36'sd127, '0, '0, 1'b1);
        send(KIND_TICK, 36'sd128, '0, '0, 1'b1);
        // saturated differences both ways, heading error wrapping several times
        send(KIND_TARGET, POS_MAX, POS_MAX, HD_MAX, 1'b1);
        send(KIND_TICK, POS_MIN, POS_MIN, HD_MIN, 1'b1);
        send(KIND_TARGET, POS_MIN, POS_MIN, HD_MIN, 1'b0);
        send(KIND_TICK, POS_MAX, POS_MAX, HD_MAX, 1'b1);
        send(KIND_TICK, POS_MAX, POS_MIN, '0, 1'b1);
        // heading error at and just past pi and pi/4
        send(KIND_TARGET, '0, '0, '0, 1'b1);
        send(KIND_TICK, 36'sd1000, '0, -16'sd12868, 1'b1);
        send(KIND_TICK, 36'sd1000, '0, 16'sd12868, 1'b1);
        send(KIND_TICK, 36'sd1000, '0, -16'sd12869, 1'b1);
        send(KIND_TICK, 36'sd1000, '0, 16'sd12869, 1'b1);
        send(KIND_TICK, 36'sd1000, '0, -16'sd3217, 1'b1);
        send(KIND_TICK, 36'sd1000, '0, -16'sd3218, 1'b1);
        send(KIND_TICK, 36'sd1000, '0, 16'sd3218, 1'b1);
        send(KIND_TICK, -36'sd5000, 36'sd3000, '0, 1'b1);
        send(KIND_TICK, 36'sd60, 36'sd40, 16'sd100, 1'b1);

        for (int s = 0; s < N_SETTINGS; s++)
        begin
            drain();
            if (s == 3)
            begin
                src_idle = 49;
                snk_idle = 25;
            end
            else if (s == 6)
            begin
                src_idle = 0;
                snk_idle = 0;
            end
            apply_setting(s);
            repeat (RANDOM_ITEMS / N_SETTINGS) random_item();
        end
        drain();

        $display("Run: %0d transactions in over %0d register settings, %0d commands compared.",
                 sent, N_SETTINGS + 1, checked);
        $display("Covered zero and full-scale gains, limits and tolerance under three idle mixes.");
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
